/* rtl/wis_pkg.sv */
// ----------------------------------------------------------------------------
// wis_pkg
// Shared types and constants of the weighted index sampler: command, status
// and register codes, controller states and the controller/datapath bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package wis_pkg;

    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_DRAW   = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    localparam logic [1:0] REG_SEED_FIRST  = 2'd0;
    localparam logic [1:0] REG_SEED_SECOND = 2'd1;
    localparam logic [1:0] REG_SEED_THIRD  = 2'd2;
    localparam logic [1:0] REG_REMOVE      = 2'd3;

    localparam logic [63:0] SEED_FIRST_RST  = 64'd123456789;
    localparam logic [63:0] SEED_SECOND_RST = 64'd362436069;
    localparam logic [63:0] SEED_THIRD_RST  = 64'd521288629;

    // bit-serial remainder: one dividend bit per cycle
    localparam int DIV_STEPS = 64;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_ZERO  = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef enum logic [11:0] {
        S_IDLE     = 12'b0000_0000_0001,
        S_APP      = 12'b0000_0000_0010,
        S_CLR      = 12'b0000_0000_0100,
        S_TOT_RD   = 12'b0000_0000_1000,
        S_TOT_CHK  = 12'b0000_0001_0000,
        S_GEN      = 12'b0000_0010_0000,
        S_DIV      = 12'b0000_0100_0000,
        S_SCAN_RD  = 12'b0000_1000_0000,
        S_SCAN_CMP = 12'b0001_0000_0000,
        S_SH_RD    = 12'b0010_0000_0000,
        S_SH_WR    = 12'b0100_0000_0000,
        S_RESULT   = 12'b1000_0000_0000
    } t_state;

    typedef struct packed {
        logic    accept;
        logic    append;
        logic    clear;
        logic    set_status;
        t_status status;
        logic    rd_total;
        logic    tot_latch;
        logic    gen_step;
        logic    div_start;
        logic    div_step;
        logic    scan_init;
        logic    scan_rd;
        logic    scan_next;
        logic    take_hit;
        logic    shift_rd;
        logic    shift_wr;
        logic    shrink;
        logic    res_load;
    } t_dp_cmd;

    typedef struct packed {
        logic empty;
        logic full;
        logic total_zero;
        logic div_last;
        logic hit;
        logic shift_end;
    } t_dp_stat;

    typedef struct packed {
        logic [2:0]  wr;
        logic [63:0] data;
    } t_seed_wr;

endpackage

`default_nettype wire

/* rtl/wis_ram.sv */
// ----------------------------------------------------------------------------
// wis_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module wis_ram #(
    parameter int WIDTH = 38,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* rtl/wis_ctrl.sv */
// ----------------------------------------------------------------------------
// wis_ctrl
// Sequencer of the sampler: takes one item at a time, steps the datapath
// through append, clear or draw (an unknown command goes straight to the result),
// and owns the result valid flag.
`default_nettype none

module wis_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [1:0]        i_command,
    input  wire logic              i_remove,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output wis_pkg::t_dp_cmd       o_cmd,
    input  wire wis_pkg::t_dp_stat i_stat
);

    import wis_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    case (i_command)
                        CMD_APPEND: n_state = S_APP;
                        CMD_DRAW:   n_state = S_TOT_RD;
                        CMD_CLEAR:  n_state = S_CLR;
                        default:    n_state = S_RESULT;
                    endcase
                end
            end
            S_APP: begin
                if (i_stat.full) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_FULL;
                end else begin
                    o_cmd.append = 1'b1;
                end
                n_state = S_RESULT;
            end
            S_CLR: begin
                o_cmd.clear = 1'b1;
                n_state     = S_RESULT;
            end
            S_TOT_RD: begin
                if (i_stat.empty) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_EMPTY;
                    n_state          = S_RESULT;
                end else begin
                    o_cmd.rd_total = 1'b1;
                    n_state        = S_TOT_CHK;
                end
            end
            S_TOT_CHK: begin
                if (i_stat.total_zero) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_ZERO;
                    n_state          = S_RESULT;
                end else begin
                    o_cmd.tot_latch = 1'b1;
                    o_cmd.gen_step  = 1'b1;
                    n_state         = S_GEN;
                end
            end
            S_GEN: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                o_cmd.scan_rd = 1'b1;
                n_state       = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                if (i_stat.hit) begin
                    o_cmd.take_hit = 1'b1;
                    n_state        = i_remove ? S_SH_RD : S_RESULT;
                end else begin
                    o_cmd.scan_next = 1'b1;
                    n_state         = S_SCAN_RD;
                end
            end
            S_SH_RD: begin
                if (i_stat.shift_end) begin
                    o_cmd.shrink = 1'b1;
                    n_state      = S_RESULT;
                end else begin
                    o_cmd.shift_rd = 1'b1;
                    n_state        = S_SH_WR;
                end
            end
            S_SH_WR: begin
                o_cmd.shift_wr = 1'b1;
                n_state        = S_SH_RD;
            end
            S_RESULT: begin
                // hold until the result register is free
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        if (o_cmd.res_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

/* rtl/wis_dp.sv */
// ----------------------------------------------------------------------------
// wis_dp
// Datapath of the sampler: xorshift96 generator, bit-serial remainder unit,
// CDF table in RAM with its fill count, scan and shift-down registers, and
// the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module wis_dp #(
    parameter int MAX_ENTRIES = 64,
    parameter int WEIGHT_BITS = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire wis_pkg::t_dp_cmd  i_cmd,
    output wis_pkg::t_dp_stat      o_stat,
    input  wire wis_pkg::t_seed_wr i_seed_wr,
    input  wire logic [31:0]       i_cumulative_weight,
    output logic [5:0]             o_drawn_index,
    output logic [6:0]             o_entries_left,
    output logic [1:0]             o_status
);

    import wis_pkg::*;

    localparam int IW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int WB = WEIGHT_BITS;
    localparam int RW = WB + 6;

    logic [63:0]          r_gen1, r_gen2, r_gen3;
    logic [CW-1:0]        r_count;
    logic [WB-1:0]        r_weight, r_total, r_rem, r_prev, r_dec;
    logic [63:0]          r_divd;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic [IW-1:0]        r_i;
    logic [CW-1:0]        r_j;
    t_status              r_status;
    logic [5:0]           r_drawn;
    logic [5:0]           r_out_index;
    logic [6:0]           r_out_left;
    t_status              r_out_status;

    logic          ram_we;
    logic [IW-1:0] ram_waddr, ram_raddr;
    logic [RW-1:0] ram_wdata, ram_rdata;
    logic [WB-1:0] rd_w;
    logic [5:0]    rd_org;
    logic [CW-1:0] cnt_m1, j_m1;
    logic [63:0]   xs_t;
    logic [WB:0]   rem_sh;
    logic          rem_ge;
    logic [WB-1:0] rem_nx;

    assign rd_w   = ram_rdata[WB-1:0];
    assign rd_org = ram_rdata[RW-1:WB];
    assign cnt_m1 = r_count - CW'(1);
    assign j_m1   = r_j - CW'(1);

    assign xs_t = (r_gen1 ^ (r_gen1 << 16)) ^ ((r_gen1 ^ (r_gen1 << 16)) >> 5);

    assign rem_sh = {r_rem, r_divd[63]};
    assign rem_ge = (rem_sh >= {1'b0, r_total});
    assign rem_nx = rem_ge ? WB'(rem_sh - {1'b0, r_total}) : rem_sh[WB-1:0];

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_count[IW-1:0];
        ram_wdata = {6'(r_count), r_weight};
        if (i_cmd.append) begin
            ram_we = 1'b1;
        end else if (i_cmd.shift_wr) begin
            ram_we    = 1'b1;
            ram_waddr = j_m1[IW-1:0];
            ram_wdata = {rd_org, WB'(rd_w - r_dec)};
        end
    end

    always_comb begin
        ram_raddr = r_i;
        if (i_cmd.rd_total) begin
            ram_raddr = cnt_m1[IW-1:0];
        end else if (i_cmd.shift_rd) begin
            ram_raddr = r_j[IW-1:0];
        end
    end

    wis_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        o_stat.empty      = (r_count == '0);
        o_stat.full       = (r_count == CW'(MAX_ENTRIES));
        o_stat.total_zero = (rd_w == '0);
        o_stat.div_last   = (r_div_cnt == DIV_CNT_W'(DIV_STEPS - 1));
        o_stat.hit        = (rd_w > r_rem);
        o_stat.shift_end  = (r_j >= r_count);
    end

    // control state: generator and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen1  <= SEED_FIRST_RST;
            r_gen2  <= SEED_SECOND_RST;
            r_gen3  <= SEED_THIRD_RST;
            r_count <= '0;
        end else begin
            if (i_cmd.gen_step) begin
                r_gen1 <= r_gen2;
                r_gen2 <= r_gen3;
                r_gen3 <= (xs_t ^ (xs_t << 1)) ^ r_gen2 ^ r_gen3;
            end else begin
                if (i_seed_wr.wr[0]) r_gen1 <= i_seed_wr.data;
                if (i_seed_wr.wr[1]) r_gen2 <= i_seed_wr.data;
                if (i_seed_wr.wr[2]) r_gen3 <= i_seed_wr.data;
            end
            if (i_cmd.append) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.clear) begin
                r_count <= '0;
            end else if (i_cmd.shrink) begin
                r_count <= cnt_m1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_weight <= WB'(i_cumulative_weight);
            r_status <= ST_OK;
            r_drawn  <= '0;
        end
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status;
        end
        if (i_cmd.tot_latch) begin
            r_total <= rd_w;
        end
        if (i_cmd.div_start) begin
            r_rem     <= '0;
            r_divd    <= r_gen3;
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem     <= rem_nx;
            r_divd    <= {r_divd[62:0], 1'b0};
            r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
        end
        if (i_cmd.scan_init) begin
            r_i    <= '0;
            r_prev <= '0;
        end else if (i_cmd.scan_next) begin
            r_i    <= r_i + IW'(1);
            r_prev <= rd_w;
        end
        if (i_cmd.take_hit) begin
            r_drawn <= rd_org;
            r_dec   <= rd_w - r_prev;
            r_j     <= CW'(r_i) + CW'(1);
        end else if (i_cmd.shift_wr) begin
            r_j <= r_j + CW'(1);
        end
        if (i_cmd.res_load) begin
            r_out_index  <= r_drawn;
            r_out_left   <= 7'(r_count);
            r_out_status <= r_status;
        end
    end

    assign o_drawn_index  = r_out_index;
    assign o_entries_left = r_out_left;
    assign o_status       = r_out_status;

endmodule

`default_nettype wire

/* rtl/weighted_index_sampler.sv */
// ----------------------------------------------------------------------------
// weighted_index_sampler
// Weighted index sampler over a cumulative-weight table with optional removal.
// ----------------------------------------------------------------------------
// One item is taken at a time. Append and clear pass through their own step
// and the result step. Every item also waits in the result step while the
// result register is still occupied and stalled. A draw reads the total, runs
// the bit-serial remainder unit, then scans the table up to the hit slot, and
// in remove mode shifts the entries above it down; the scan and shift-down
// read and then compare or write one entry at a time through the single read
// port of the table RAM. A new item is taken while a finished result still waits.
`default_nettype none

module weighted_index_sampler #(
    parameter int MAX_ENTRIES = 64,
    parameter int WEIGHT_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic      [63:0] prdata,
    output logic             pready,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_command,
    input  wire logic [31:0] i_cumulative_weight,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [5:0]       o_drawn_index,
    output logic [6:0]       o_entries_left,
    output logic [1:0]       o_status
);

    import wis_pkg::*;

    logic [63:0] r_seed1, r_seed2, r_seed3;
    logic        r_remove;
    logic        cfg_wr;
    logic [1:0]  cfg_idx;
    t_seed_wr    seed_wr;
    t_dp_cmd     dp_cmd;
    t_dp_stat    dp_stat;

    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:3];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed1  <= SEED_FIRST_RST;
            r_seed2  <= SEED_SECOND_RST;
            r_seed3  <= SEED_THIRD_RST;
            r_remove <= 1'b0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_SEED_FIRST:  r_seed1  <= pwdata;
                REG_SEED_SECOND: r_seed2  <= pwdata;
                REG_SEED_THIRD:  r_seed3  <= pwdata;
                REG_REMOVE:      r_remove <= pwdata[0];
                default:         r_remove <= r_remove;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_SEED_FIRST:  prdata = r_seed1;
            REG_SEED_SECOND: prdata = r_seed2;
            REG_SEED_THIRD:  prdata = r_seed3;
            REG_REMOVE:      prdata = {63'd0, r_remove};
            default:         prdata = '0;
        endcase
    end

    // seed writes load the generator directly
    assign seed_wr.wr   = {cfg_wr && (cfg_idx == REG_SEED_THIRD),
                           cfg_wr && (cfg_idx == REG_SEED_SECOND),
                           cfg_wr && (cfg_idx == REG_SEED_FIRST)};
    assign seed_wr.data = pwdata;

    wis_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_command   (i_command),
        .i_remove    (r_remove),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (dp_cmd),
        .i_stat      (dp_stat)
    );

    wis_dp #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (dp_cmd),
        .o_stat              (dp_stat),
        .i_seed_wr           (seed_wr),
        .i_cumulative_weight (i_cumulative_weight),
        .o_drawn_index       (o_drawn_index),
        .o_entries_left      (o_entries_left),
        .o_status            (o_status)
    );

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("sampler took an item without going busy");

    a_err_no_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_OK)) |-> (o_drawn_index == 6'd0))
        else $error("error result carries a drawn index");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_FULL)) |-> (o_entries_left == 7'(MAX_ENTRIES)))
        else $error("full status with table not full");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_EMPTY)) |-> (o_entries_left == 7'd0))
        else $error("empty status with entries left");

endmodule

`default_nettype wire
